@@ sv/bdtm_pkg.sv @@
// Package for the birth-death tridiagonal matrix-vector block: types, codes and helpers.
`default_nettype none
package bdtm_pkg;

  localparam int SUM_W    = 130;
  localparam int MUL_A_W  = 65;
  localparam int MUL_B_W  = 64;
  localparam int PROD_W   = 129;
  localparam int DIGIT_W  = 16;
  localparam int MUL_STEPS = MUL_B_W / DIGIT_W;
  localparam int DIV_STEPS = 64;

  localparam logic [2:0] CFG_POP_SIZE    = 3'd0;
  localparam logic [2:0] CFG_LINEAGES    = 3'd1;
  localparam logic [2:0] CFG_BIRTH_RATE  = 3'd2;
  localparam logic [2:0] CFG_DEATH_RATE  = 3'd3;
  localparam logic [2:0] CFG_SAMPLE_RATE = 3'd4;
  localparam logic [2:0] CFG_DIAG_SHIFT  = 3'd5;
  localparam logic [2:0] CFG_CAPACITY    = 3'd6;
  localparam logic [2:0] CFG_RATE_MODEL  = 3'd7;

  typedef struct packed {
    logic signed [63:0] element;
    logic signed [63:0] scale;
    logic               final_req;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic [10:0]        row;
    logic               row_last;
  } out_item_t;

  typedef struct packed {
    logic [10:0]        pop_size;
    logic [10:0]        lineages;
    logic [62:0]        birth_rate;
    logic [62:0]        death_rate;
    logic [62:0]        sample_rate;
    logic signed [63:0] diag_shift;
    logic [62:0]        capacity;
    logic               rate_model;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_ROW_A,
    T_ROW_B
  } top_state_t;

  typedef enum logic [3:0] {
    R_IDLE,
    R_RATE_MUL,
    R_RATE_DIV,
    R_S_MUL,
    R_A_FX,
    R_B_MUL,
    R_B_FX,
    R_C_MUL,
    R_C_FX,
    R_T_FX,
    R_DONE
  } row_state_t;

  // Magnitude of a signed 64-bit value as unsigned (most negative maps to 2^63).
  function automatic logic [63:0] mag64(input logic [63:0] x);
    logic [63:0] r;
    r = x[63] ? (64'd0 - x) : x;
    return r;
  endfunction

  // Saturate a wide signed value to the signed 64-bit range.
  function automatic logic [63:0] sat64(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    logic [63:0]             r;
    hi_lim = $signed({{(SUM_W-63){1'b0}}, {63{1'b1}}});
    lo_lim = $signed({{(SUM_W-63){1'b1}}, {63{1'b0}}});
    if (v > hi_lim) begin
      r = {1'b0, {63{1'b1}}};
    end else if (v < lo_lim) begin
      r = {1'b1, {63{1'b0}}};
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/bdtm_mul.sv @@
// Shared multiplier: 65 x 64 bits, one 16-bit digit of the second operand per cycle.
`default_nettype none
module bdtm_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bdtm_pkg::MUL_A_W-1:0]  a,
  input  wire logic [bdtm_pkg::MUL_B_W-1:0]  b,
  output logic                               done,
  output logic [bdtm_pkg::PROD_W-1:0]        prod
);
  import bdtm_pkg::*;

  localparam int PP_W  = MUL_A_W + DIGIT_W;
  localparam int CNT_W = $clog2(MUL_STEPS);

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [PROD_W-1:0]  acc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [PP_W-1:0]    pp;

  // Most significant digit first: shift the accumulator up and add.
  assign pp = PP_W'(a_r) * PP_W'(b_r[MUL_B_W-1 -: DIGIT_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << DIGIT_W) + PROD_W'(pp);
      b_r   <= b_r << DIGIT_W;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

@@ sv/bdtm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the logistic rate.
`default_nettype none
module bdtm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [62:0] num_hi,
  input  wire logic [63:0] num_lo,
  input  wire logic [62:0] den,
  output logic             done,
  output logic [63:0]      quot
);
  import bdtm_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [62:0]      r_r;
  logic [63:0]      lo_r;
  logic [63:0]      q_r;
  logic [62:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [63:0]      r2;
  logic             ge;

  assign r2 = {r_r, lo_r[63]};
  assign ge = r2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The upper half of the numerator is already below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      r_r   <= num_hi;
      lo_r  <= num_lo;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      r_r  <= ge ? 63'(r2 - {1'b0, den_r}) : r2[62:0];
      lo_r <= lo_r << 1;
      q_r  <= {q_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

@@ sv/bdtm_row.sv @@
// Row engine: sequences the shared multiplier and divider to evaluate one output row.
`default_nettype none
module bdtm_row #(
  parameter int IDX_W     = 11,
  parameter int FRAC_BITS = 40
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                ack,
  input  wire logic [IDX_W-1:0]    m,
  input  wire logic [63:0]         pl,
  input  wire logic [63:0]         pc,
  input  wire logic [63:0]         pu,
  input  wire logic                upper,
  input  wire logic [63:0]         scale,
  input  wire logic [IDX_W-1:0]    pop_eff,
  input  wire bdtm_pkg::cfg_regs_t cfg,
  output logic                     idle,
  output logic                     done,
  output logic [63:0]              result
);
  import bdtm_pkg::*;

  localparam int CW   = (IDX_W > 11) ? IDX_W : 11;
  localparam int CMPW = (IDX_W + FRAC_BITS > 64) ? IDX_W + FRAC_BITS : 64;

  row_state_t state_r, state_nxt;

  logic [IDX_W-1:0] m_r;
  logic [63:0]      pl_r, pc_r, pu_r;
  logic             upper_r;
  logic [62:0]      l_r;
  logic [62:0]      diff_r;
  logic [63:0]      coef_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [63:0]      result_r;
  logic             issued_r;

  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_prod;
  logic               div_start, div_done;
  logic [63:0]        div_q;
  logic               term_sign;

  logic               below;
  logic [CMPW-1:0]    mf;
  logic               mf_ge_k;
  logic [PROD_W-1:0]  shifted;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] neg_sm;
  logic signed [SUM_W-1:0] shift_w;
  logic [63:0]        t_sat;
  logic               m_zero;

  bdtm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  bdtm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (mul_prod[126:64]),
    .num_lo (mul_prod[63:0]),
    .den    (cfg.capacity),
    .done   (div_done),
    .quot   (div_q)
  );

  assign below   = CW'(m) < CW'(cfg.lineages);
  assign mf      = CMPW'(m) << FRAC_BITS;
  assign mf_ge_k = mf >= CMPW'(cfg.capacity);
  assign m_zero  = (m_r == '0);

  assign shifted = mul_prod >> FRAC_BITS;
  assign term    = term_sign ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
  assign neg_sm  = -$signed({1'b0, mul_prod});
  assign shift_w = SUM_W'(cfg.diag_shift);
  assign t_sat   = sat64(sum_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      R_IDLE: begin
        if (start) begin
          if (below) begin
            state_nxt = R_DONE;
          end else if (m == '0 || cfg.rate_model || mf_ge_k) begin
            state_nxt = R_S_MUL;
          end else begin
            state_nxt = R_RATE_MUL;
          end
        end
      end
      R_RATE_MUL: if (mul_done) state_nxt = R_RATE_DIV;
      R_RATE_DIV: if (div_done) state_nxt = R_S_MUL;
      R_S_MUL:    if (mul_done) state_nxt = R_A_FX;
      R_A_FX: begin
        if (mul_done) begin
          state_nxt = upper_r ? R_B_MUL : (m_zero ? R_T_FX : R_C_MUL);
        end
      end
      R_B_MUL:    if (mul_done) state_nxt = R_B_FX;
      R_B_FX:     if (mul_done) state_nxt = m_zero ? R_T_FX : R_C_MUL;
      R_C_MUL:    if (mul_done) state_nxt = R_C_FX;
      R_C_FX:     if (mul_done) state_nxt = R_T_FX;
      R_T_FX:     if (mul_done) state_nxt = R_DONE;
      R_DONE:     if (ack) state_nxt = R_IDLE;
      default:    state_nxt = R_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    term_sign = 1'b0;
    case (state_r)
      R_RATE_MUL: begin
        mul_start = !issued_r;
        mul_a     = MUL_A_W'(cfg.birth_rate);
        mul_b     = MUL_B_W'(diff_r);
      end
      R_RATE_DIV: div_start = !issued_r;
      R_S_MUL: begin
        mul_start = !issued_r;
        mul_a     = MUL_A_W'(l_r) + MUL_A_W'(cfg.sample_rate) + MUL_A_W'(cfg.death_rate);
        mul_b     = MUL_B_W'(m_r);
      end
      R_A_FX: begin
        mul_start = !issued_r;
        mul_a     = MUL_A_W'(mag64(coef_r));
        mul_b     = mag64(pc_r);
        term_sign = coef_r[63] ^ pc_r[63];
      end
      R_B_MUL: begin
        mul_start = !issued_r;
        mul_a     = MUL_A_W'(l_r);
        mul_b     = MUL_B_W'(m_r) + MUL_B_W'(cfg.lineages);
      end
      R_B_FX: begin
        mul_start = !issued_r;
        mul_a     = MUL_A_W'(mag64(coef_r));
        mul_b     = mag64(pu_r);
        term_sign = coef_r[63] ^ pu_r[63];
      end
      R_C_MUL: begin
        mul_start = !issued_r;
        mul_a     = MUL_A_W'(cfg.death_rate);
        mul_b     = MUL_B_W'(m_r) - MUL_B_W'(cfg.lineages);
      end
      R_C_FX: begin
        mul_start = !issued_r;
        mul_a     = MUL_A_W'(mag64(coef_r));
        mul_b     = mag64(pl_r);
        term_sign = coef_r[63] ^ pl_r[63];
      end
      R_T_FX: begin
        mul_start = !issued_r;
        mul_a     = MUL_A_W'(mag64(scale));
        mul_b     = mag64(t_sat);
        term_sign = scale[63] ^ t_sat[63];
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= R_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_done || div_done) begin
        issued_r <= 1'b0;
      end else if (mul_start || div_start) begin
        issued_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        if (start) begin
          m_r      <= m;
          pl_r     <= pl;
          pc_r     <= pc;
          pu_r     <= pu;
          upper_r  <= upper;
          diff_r   <= 63'(CMPW'(cfg.capacity) - mf);
          result_r <= '0;
          if (m == '0) begin
            l_r <= '0;
          end else if (cfg.rate_model) begin
            l_r <= (m <= pop_eff) ? cfg.birth_rate : '0;
          end else begin
            l_r <= '0;
          end
        end
      end
      R_RATE_DIV: if (div_done) l_r <= div_q[62:0];
      R_S_MUL:    if (mul_done) coef_r <= sat64(neg_sm - shift_w);
      R_A_FX:     if (mul_done) sum_r <= term;
      R_B_MUL, R_C_MUL: begin
        if (mul_done) coef_r <= sat64($signed({1'b0, mul_prod}));
      end
      R_B_FX, R_C_FX: if (mul_done) sum_r <= sum_r + term;
      R_T_FX:     if (mul_done) result_r <= sat64(term);
      default: begin
        result_r <= result_r;
      end
    endcase
  end

  assign idle   = (state_r == R_IDLE);
  assign done   = (state_r == R_DONE);
  assign result = result_r;

endmodule
`default_nettype wire

@@ sv/birth_death_tridiagonal_matvec.sv @@
// Top level: config registers, three-element window, row sequencing and output register.
// Row work: a row runs seven multiplies on the shared 65x16 unit; the logistic rate adds a
//   multiply and a division by the capacity. A row without upper term skips the upper-term
//   multiplies, and a row below the lineage count is zero and skips them all.
// Flow: the input stalls while the rows of a transaction are worked (the second row on the
//   last element) and while the output register waits to be taken.
// Reset: synchronous, active low; clears the window, index, config and control state.
`default_nettype none
module birth_death_tridiagonal_matvec #(
  parameter int MAX_POP   = 1024,
  parameter int FRAC_BITS = 40
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bdtm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bdtm_pkg::out_item_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  import bdtm_pkg::*;

  localparam int IDX_W = $clog2(MAX_POP + 1);
  localparam int CW    = (IDX_W > 11) ? IDX_W : 11;

  cfg_regs_t  cfg_r;
  top_state_t state_r, state_nxt;

  // Window: prev_r holds p[m-2], cur_r holds p[m-1].
  logic [63:0]      prev_r, cur_r, scale_r;
  logic [IDX_W-1:0] idx_r;

  // Snapshot of the accepted transaction for the row engine.
  logic [63:0]      w_pl_r, w_pc_r, w_e_r;
  logic [IDX_W-1:0] m_r;
  logic             last_r;

  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             accept;
  logic             last_in;
  logic [IDX_W-1:0] pop_eff;
  logic             slot_free;
  logic             eng_start, eng_ack, eng_idle, eng_done;
  logic [63:0]      eng_result;
  logic [IDX_W-1:0] req_m;
  logic [63:0]      req_pl, req_pc, req_pu;
  logic             req_upper;

  assign pop_eff   = (CW'(cfg_r.pop_size) > CW'(MAX_POP)) ? IDX_W'(MAX_POP)
                                                          : IDX_W'(cfg_r.pop_size);
  assign accept    = in_valid && !in_stall;
  assign last_in   = in_data.final_req || (idx_r >= pop_eff);
  assign slot_free = !out_valid_r || !out_stall;

  // Config writes must arrive only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pop_size    <= '0;
      cfg_r.lineages    <= '0;
      cfg_r.birth_rate  <= '0;
      cfg_r.death_rate  <= '0;
      cfg_r.sample_rate <= '0;
      cfg_r.diag_shift  <= '0;
      cfg_r.capacity    <= 63'(64'd1 << FRAC_BITS);
      cfg_r.rate_model  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POP_SIZE:    cfg_r.pop_size    <= cfg_data[10:0];
        CFG_LINEAGES:    cfg_r.lineages    <= cfg_data[10:0];
        CFG_BIRTH_RATE:  cfg_r.birth_rate  <= cfg_data[62:0];
        CFG_DEATH_RATE:  cfg_r.death_rate  <= cfg_data[62:0];
        CFG_SAMPLE_RATE: cfg_r.sample_rate <= cfg_data[62:0];
        CFG_DIAG_SHIFT:  cfg_r.diag_shift  <= cfg_data;
        CFG_CAPACITY:    cfg_r.capacity    <= cfg_data[62:0];
        CFG_RATE_MODEL:  cfg_r.rate_model  <= cfg_data[0];
        default:         cfg_r.rate_model  <= cfg_r.rate_model;
      endcase
    end
  end

  // Next state: leave idle on a transaction that yields rows, step through the one or two rows it yields.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          if (idx_r != '0) begin
            state_nxt = T_ROW_A;
          end else if (last_in) begin
            state_nxt = T_ROW_B;
          end
        end
      end
      T_ROW_A: if (eng_ack) state_nxt = last_r ? T_ROW_B : T_IDLE;
      T_ROW_B: if (eng_ack) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // Outputs: row request muxing and engine handshake.
  always_comb begin
    in_stall  = (state_r != T_IDLE);
    eng_start = 1'b0;
    eng_ack   = 1'b0;
    req_m     = m_r;
    req_pl    = w_pc_r;
    req_pc    = w_e_r;
    req_pu    = '0;
    req_upper = 1'b0;
    case (state_r)
      T_ROW_A: begin
        eng_start = eng_idle;
        eng_ack   = eng_done && slot_free;
        req_m     = m_r - 1'b1;
        req_pl    = w_pl_r;
        req_pc    = w_pc_r;
        req_pu    = w_e_r;
        req_upper = 1'b1;
      end
      T_ROW_B: begin
        eng_start = eng_idle;
        eng_ack   = eng_done && slot_free;
      end
      default: begin
        eng_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      cur_r       <= '0;
      scale_r     <= '0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (eng_ack) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        if (idx_r == '0) scale_r <= in_data.scale;
        // Advance the window, or clear it at the end of a vector.
        if (last_in) begin
          prev_r <= '0;
          cur_r  <= '0;
          idx_r  <= '0;
        end else begin
          prev_r <= cur_r;
          cur_r  <= in_data.element;
          idx_r  <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_pl_r <= prev_r;
      w_pc_r <= cur_r;
      w_e_r  <= in_data.element;
      m_r    <= idx_r;
      last_r <= last_in;
    end
    if (eng_ack) begin
      out_data_r.result   <= eng_result;
      out_data_r.row      <= 11'(req_m);
      out_data_r.row_last <= (state_r == T_ROW_B);
    end
  end

  bdtm_row #(
    .IDX_W     (IDX_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (eng_start),
    .ack     (eng_ack),
    .m       (req_m),
    .pl      (req_pl),
    .pc      (req_pc),
    .pu      (req_pu),
    .upper   (req_upper),
    .scale   (scale_r),
    .pop_eff (pop_eff),
    .cfg     (cfg_r),
    .idle    (eng_idle),
    .done    (eng_done),
    .result  (eng_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ sim/bdtm_checker.sv @@
// Checker for the birth-death matrix-vector block: mirrors config, predicts rows, compares.
module bdtm_checker #(
  parameter int MAX_POP   = 1024,
  parameter int FRAC_BITS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  bdtm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  bdtm_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output int                  fail_count,
  output int                  rows_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdtm_pkg::*;

  typedef logic signed [129:0] wide_t;

  cfg_regs_t   regs;
  logic [63:0] win_prev, win_cur, alpha;
  logic [10:0] idx;
  out_item_t   rows_due[$];

  function automatic wide_t uwide(input logic [63:0] v);
    return $signed({66'd0, v});
  endfunction

  function automatic logic [63:0] clamp64(input wide_t v);
    wide_t hi_lim, lo_lim;
    hi_lim = uwide(64'h7FFF_FFFF_FFFF_FFFF);
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (v < lo_lim) return 64'h8000_0000_0000_0000;
    return v[63:0];
  endfunction

  // Truncate magnitude product toward zero, then reapply sign.
  function automatic wide_t fx_product(input logic [63:0] x, input logic [63:0] y);
    logic [63:0]  mx, my;
    logic [127:0] p;
    wide_t        r;
    mx = x[63] ? (64'd0 - x) : x;
    my = y[63] ? (64'd0 - y) : y;
    p  = {64'd0, mx} * {64'd0, my};
    p  = p >> FRAC_BITS;
    r  = $signed({2'b00, p});
    if (x[63] ^ y[63]) r = -r;
    return r;
  endfunction

  function automatic logic [10:0] top_index();
    return (regs.pop_size > MAX_POP) ? 11'(MAX_POP) : regs.pop_size;
  endfunction

  function automatic logic [63:0] birth_at(input logic [10:0] m);
    logic [127:0] mf, num, q;
    logic [63:0]  capw;
    if (m == 0) return 64'd0;
    if (regs.rate_model) return (m <= top_index()) ? {1'b0, regs.birth_rate} : 64'd0;
    capw = {1'b0, regs.capacity};
    mf   = {117'd0, m} << FRAC_BITS;
    if (mf >= {64'd0, capw}) return 64'd0;   // past capacity, or capacity zero
    num = {65'd0, regs.birth_rate} * ({64'd0, capw} - mf);
    q   = num / {64'd0, capw};
    return q[63:0];
  endfunction

  function automatic logic [63:0] row_value(input logic [10:0] m, input logic [63:0] pl,
                                            input logic [63:0] pc, input logic [63:0] pu,
                                            input logic has_upper);
    logic [63:0] lam, a, b, c, t;
    wide_t       wm, wk, s, sum;
    if (m < regs.lineages) return 64'd0;
    lam = birth_at(m);
    wm  = uwide({53'd0, m});
    wk  = uwide({53'd0, regs.lineages});
    s   = uwide(lam) + uwide({1'b0, regs.sample_rate}) + uwide({1'b0, regs.death_rate});
    a   = clamp64(-(s * wm) - $signed({{66{regs.diag_shift[63]}}, regs.diag_shift}));
    sum = fx_product(a, pc);
    if (has_upper) begin
      b   = clamp64(uwide(lam) * (wm + wk));
      sum = sum + fx_product(b, pu);
    end
    if (m > 0) begin
      c   = clamp64(uwide({1'b0, regs.death_rate}) * (wm - wk));
      sum = sum + fx_product(c, pl);
    end
    t = clamp64(sum);
    return clamp64(fx_product(alpha, t));
  endfunction

  assign rows_pending = rows_due.size();

  always @(posedge clk) begin
    logic      last;
    out_item_t row_item, want;
    if (!rst_n) begin
      regs.pop_size    <= '0;
      regs.lineages    <= '0;
      regs.birth_rate  <= '0;
      regs.death_rate  <= '0;
      regs.sample_rate <= '0;
      regs.diag_shift  <= '0;
      regs.capacity    <= 63'(64'd1 << FRAC_BITS);
      regs.rate_model  <= 1'b0;
      win_prev         <= '0;
      win_cur          <= '0;
      alpha             = '0;
      idx              <= '0;
      fail_count       <= 0;
      rows_due.delete();
    end else begin
      // Predict the rows released by an accepted input transaction.
      if (in_valid && !in_stall) begin
        last = in_data.final_req || (idx >= top_index());
        if (idx == 0) alpha = in_data.scale;
        if (idx >= 1) begin
          row_item.result   = row_value(idx - 11'd1, win_prev, win_cur, in_data.element, 1'b1);
          row_item.row      = idx - 11'd1;
          row_item.row_last = 1'b0;
          rows_due.push_back(row_item);
        end
        if (last) begin
          row_item.result   = row_value(idx, win_cur, in_data.element, 64'd0, 1'b0);
          row_item.row      = idx;
          row_item.row_last = 1'b1;
          rows_due.push_back(row_item);
          win_prev <= '0;
          win_cur  <= '0;
          idx      <= '0;
        end else begin
          win_prev <= win_cur;
          win_cur  <= in_data.element;
          idx      <= idx + 11'd1;
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_POP_SIZE:    regs.pop_size    <= cfg_data[10:0];
          CFG_LINEAGES:    regs.lineages    <= cfg_data[10:0];
          CFG_BIRTH_RATE:  regs.birth_rate  <= cfg_data[62:0];
          CFG_DEATH_RATE:  regs.death_rate  <= cfg_data[62:0];
          CFG_SAMPLE_RATE: regs.sample_rate <= cfg_data[62:0];
          CFG_DIAG_SHIFT:  regs.diag_shift  <= cfg_data;
          CFG_CAPACITY:    regs.capacity    <= cfg_data[62:0];
          CFG_RATE_MODEL:  regs.rate_model  <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (rows_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected row %0d result %h", out_data.row, out_data.result);
          fail_count <= fail_count + 1;
        end else begin
          want = rows_due.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("row mismatch: want row %0d last %b result %h, got row %0d last %b result %h",
                       want.row, want.row_last, want.result,
                       out_data.row, out_data.row_last, out_data.result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/birth_death_tridiagonal_matvec_tb.sv @@
// Testbench top: clock, reset, stimulus, receiver back-pressure and the verdict.
module birth_death_tridiagonal_matvec_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdtm_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 200;   // idle time after the last row has arrived

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = CFG_POP_SIZE;
  logic [63:0] cfg_data = '0;
  int          fail_count, rows_pending;
  int          cycles = 0;
  bit          quiet = 0;       // no idling on either side while set
  bit          hold_req = 0;    // asks the receiver for one long hold-off
  bit          hold_done = 0;

  birth_death_tridiagonal_matvec u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  bdtm_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_wr_en, .cfg_index, .cfg_data, .fail_count, .rows_pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: draw a stall length per transaction, with one long hold-off on request.
  initial begin : receiver
    int n;
    @(posedge rst_n);
    forever begin
      n = quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
      if (hold_req && !hold_done) begin
        n = 400;
        hold_done = 1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7FFF_FFFF_FFFF_FFFF;
      2, 3: v = {$urandom, $urandom};
      default: begin
        v = {32'd0, $urandom} << $urandom_range(0, 24);
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [63:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'd0;
      2: return {$urandom_range(0, 32'h7FFF_FFFF), $urandom};
      default: return {32'd0, $urandom} << $urandom_range(0, 12);
    endcase
  endfunction

  // Offer one transaction after a random gap and hold it until taken.
  task automatic offer(input logic [63:0] elem, input logic [63:0] alpha, input logic fin);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.element   <= elem;
    in_data.scale     <= alpha;
    in_data.final_req <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  // Pause until every row has arrived and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] which, input logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic setup(input logic [63:0] pop, input logic [63:0] ki,
                       input logic [63:0] beta, input logic [63:0] mu,
                       input logic [63:0] psi, input logic [63:0] shift,
                       input logic [63:0] cap, input logic [63:0] model);
    drain();
    write_reg(CFG_POP_SIZE, pop);
    write_reg(CFG_LINEAGES, ki);
    write_reg(CFG_BIRTH_RATE, beta);
    write_reg(CFG_DEATH_RATE, mu);
    write_reg(CFG_SAMPLE_RATE, psi);
    write_reg(CFG_DIAG_SHIFT, shift);
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_RATE_MODEL, model);
  endtask

  // Send a vector of given length; mark the end only when asked.
  task automatic send_vector(input int len, input bit mark_end);
    for (int i = 0; i < len; i++)
      offer(pick_value(), pick_value(), mark_end && (i == len - 1));
  endtask

  localparam logic [63:0] ONE = 64'd1 << 40;

  initial begin : stimulus
    int n_items, vec_len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: pop_size zero makes every element a one-row vector.
    offer(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    offer(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1);

    // Logistic rate, small vector, early end by final_req.
    setup(5, 0, ONE, ONE >> 1, ONE >> 2, ONE / 10, 3 * ONE, 0);
    offer(ONE, ONE, 1'b0);
    offer(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    offer(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b0);
    offer(-ONE, 64'd0, 1'b1);
    // Runs to the population bound without final_req.
    send_vector(6, 0);

    // Constant rate with lineages, saturating rates.
    setup(4, 2, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
          64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1);
    send_vector(5, 0);

    // Zero capacity, lineages above n, shift at its top.
    setup(3, 2047, ONE, ONE, ONE, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
    send_vector(4, 0);

    // Pop size above the bound, ended early; logistic with tiny capacity.
    setup(2047, 0, ONE * 3, ONE, 0, 0, 1, 0);
    send_vector(3, 1);

    // Population at the bound, constant rate, no idling; ended early by final_req.
    setup(1024, 5, ONE, ONE >> 3, ONE >> 4, -ONE, ONE * 500, 1);
    quiet = 1;
    send_vector(40, 1);
    quiet = 0;

    // Random phases: mostly short vectors with random content; with the fixed part above
    // this keeps the whole run near 650 transactions.
    n_items = 0;
    while (n_items < 560) begin
      setup(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 12),
            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 4),
            pick_rate(), pick_rate(), pick_rate(), pick_value(),
            ($urandom_range(0, 9) == 0) ? 64'(0) : pick_rate(),
            $urandom_range(0, 1));
      quiet = ($urandom_range(0, 4) == 0);
      for (int v = 0; v < 6; v++) begin
        vec_len = $urandom_range(1, 14);
        if (n_items > 200 && !hold_req) hold_req = 1;   // block fills and stalls its input
        send_vector(vec_len, $urandom_range(0, 2) != 0);
        n_items += vec_len;
      end
      quiet = 0;
    end

    drain();
    if (fail_count == 0 && rows_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
